@@ design/rrd_pkg.sv @@
// Shared definitions for the radar report deframer.
// Holds parameter defaults, frame codes, record kinds and the frame-end command.
// No dependencies.
`default_nettype none

package rrd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int GATE_COUNT_DEF      = 9;

    // Width of the record counter; covers the report, the header and up to nine gates.
    localparam int REC_W = 4;

    localparam logic [7:0]  START_DATA    = 8'hF4;
    localparam logic [7:0]  START_ACK     = 8'hFD;
    localparam logic [7:0]  REPORT_MARKER = 8'hAA;
    localparam logic [7:0]  TYPE_ENG      = 8'd1;
    localparam logic [7:0]  TYPE_BASIC    = 8'd2;
    localparam logic [31:0] DATA_TAIL     = 32'hF8F7F6F5;
    localparam logic [31:0] ACK_TAIL      = 32'h04030201;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_BASIC  = 2'd1,
        KIND_HEADER = 2'd2,
        KIND_GATE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic start_ack;
        logic start_data;
        logic eng;
    } cmd_t;

endpackage

`default_nettype wire

@@ design/radar_report_deframer.sv @@
// Top level of the radar report deframer.
// Joins the framer, the frame byte store and the record emitter.
// Depends on rrd_pkg, rrd_store, rrd_framer and rrd_emit.
//
//   Channel  Handshake                   Payload
//   rx       rx_valid / rx_ready         rx_byte
//   record   record_valid / record_ready record_kind .. last_of_frame
//
// Bytes may arrive back to back while rx_ready is high.
// After a frame end, rx_ready stays low until the last record sits in the output
// register, while the emitter reads the store and waits out output stalls.
// Reset is asynchronous and clears the store's valid bits at once; no clearing pass.
// A record waiting in the output register does not block the next byte.
`default_nettype none

module radar_report_deframer
    import rrd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int GATE_COUNT      = GATE_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             record_valid,
    input  wire logic        record_ready,
    output logic      [1:0]  record_kind,
    output logic      [7:0]  target_state,
    output logic      [15:0] moving_distance,
    output logic      [7:0]  moving_energy,
    output logic      [15:0] still_distance,
    output logic      [7:0]  still_energy,
    output logic      [15:0] detect_distance,
    output logic      [3:0]  gate_number,
    output logic      [7:0]  moving_value,
    output logic      [7:0]  still_value,
    output logic             last_of_frame
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    logic          accept;
    logic          busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    cmd_t          cmd;

    assign rx_ready = !busy;
    assign accept   = rx_valid && rx_ready;

    rrd_framer #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .cmd     (cmd)
    );

    rrd_store #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rrd_emit #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .GATE_COUNT     (GATE_COUNT)
    ) u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .busy            (busy),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .record_valid    (record_valid),
        .record_ready    (record_ready),
        .record_kind     (record_kind),
        .target_state    (target_state),
        .moving_distance (moving_distance),
        .moving_energy   (moving_energy),
        .still_distance  (still_distance),
        .still_energy    (still_energy),
        .detect_distance (detect_distance),
        .gate_number     (gate_number),
        .moving_value    (moving_value),
        .still_value     (still_value),
        .last_of_frame   (last_of_frame)
    );

endmodule

`default_nettype wire

@@ design/rrd_store.sv @@
// Frame byte store of the radar report deframer.
// One write port, one registered read port, per-entry valid bits cleared by reset.
// Depends on nothing but its parameter.
`default_nettype none

module rrd_store #(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(MAX_FRAME_BYTES)-1:0] wr_addr,
    input  wire logic [7:0]                         wr_data,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(MAX_FRAME_BYTES)-1:0] rd_addr,
    output logic      [7:0]                         rd_data
);

    logic [7:0]                 mem_reg [MAX_FRAME_BYTES];
    logic [MAX_FRAME_BYTES-1:0] vld_reg;
    logic [7:0]                 rd_q_reg;
    logic                       rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign rd_data = rd_vld_reg ? rd_q_reg : 8'd0;

endmodule

`default_nettype wire

@@ design/rrd_framer.sv @@
// Byte framer of the radar report deframer.
// Hunts for start bytes, writes frame bytes to the store, checks length and tail.
// Depends on rrd_pkg for the frame codes and the frame-end command.
`default_nettype none

module rrd_framer
    import rrd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               accept,
    input  wire logic [7:0]                         rx_byte,
    output logic                                    wr_en,
    output logic      [$clog2(MAX_FRAME_BYTES)-1:0] wr_addr,
    output logic      [7:0]                         wr_data,
    output cmd_t                                    cmd
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [16:0] LEN_EXTRA  = 17'd10;

    logic          in_frame_reg;
    logic          is_ack_reg;
    logic [PW-1:0] pos_reg;
    logic [23:0]   tail_reg;
    logic [15:0]   len_reg;
    logic [7:0]    type_reg;
    logic [7:0]    marker_reg;

    logic [PW-1:0] pos_inc;
    logic [31:0]   tail_now;
    logic [16:0]   len_sum;
    logic          too_long;
    logic          at_check;
    logic          past_check;
    logic          full;
    logic          hit;
    logic          is_start;
    logic [7:0]    marker_now;
    logic          frame_end;

    assign pos_inc    = pos_reg + PW'(1);
    assign tail_now   = {tail_reg, rx_byte};
    assign len_sum    = {1'b0, len_reg} + LEN_EXTRA;
    assign too_long   = len_sum > 17'(MAX_FRAME_BYTES);
    assign at_check   = pos_inc == PW'(8);
    assign past_check = pos_inc >= PW'(8);
    assign full       = pos_inc >= PW'(MAX_FRAME_BYTES);
    assign hit        = is_ack_reg ? (tail_now == ACK_TAIL) : (tail_now == DATA_TAIL);
    assign is_start   = (rx_byte == START_DATA) || (rx_byte == START_ACK);
    assign marker_now = (pos_reg == PW'(7)) ? rx_byte : marker_reg;

    assign frame_end = accept && in_frame_reg && !(at_check && too_long) && past_check && hit;

    assign cmd.start_ack  = frame_end && is_ack_reg;
    assign cmd.start_data = frame_end && !is_ack_reg
                            && ((type_reg == TYPE_ENG) || (type_reg == TYPE_BASIC))
                            && (marker_now == REPORT_MARKER);
    assign cmd.eng        = type_reg == TYPE_ENG;

    assign wr_en   = accept && (in_frame_reg || is_start);
    assign wr_addr = in_frame_reg ? pos_reg[AW-1:0] : '0;
    assign wr_data = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            is_ack_reg   <= 1'b0;
            pos_reg      <= '0;
        end
        else if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (is_start)
                begin
                    in_frame_reg <= 1'b1;
                    pos_reg      <= PW'(1);
                    is_ack_reg   <= rx_byte == START_ACK;
                end
            end
            else if (at_check && too_long)
            begin
                in_frame_reg <= 1'b0;
                pos_reg      <= '0;
            end
            else if (past_check && hit)
            begin
                in_frame_reg <= 1'b0;
                pos_reg      <= pos_inc;
            end
            else if (full)
            begin
                in_frame_reg <= 1'b0;
                pos_reg      <= '0;
            end
            else
            begin
                pos_reg <= pos_inc;
            end
        end
    end

    // Header bytes kept aside: length, type and marker, plus the last three bytes for the tail.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tail_reg <= tail_now[23:0];
            if (in_frame_reg)
            begin
                if (pos_reg == PW'(4))
                begin
                    len_reg[7:0] <= rx_byte;
                end
                if (pos_reg == PW'(5))
                begin
                    len_reg[15:8] <= rx_byte;
                end
                if (pos_reg == PW'(6))
                begin
                    type_reg <= rx_byte;
                end
                if (pos_reg == PW'(7))
                begin
                    marker_reg <= rx_byte;
                end
            end
        end
    end

    // While inside a frame the write position never leaves the store.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (pos_reg != '0) && (pos_reg < PW'(MAX_FRAME_BYTES)))
        else $error("Frame position out of range.");

    // A frame that ends always returns the framer to hunting.
    a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_ack || cmd.start_data) |=> !in_frame_reg)
        else $error("Framer stayed in frame after a frame end.");

endmodule

`default_nettype wire

@@ design/rrd_emit.sv @@
// Record emitter of the radar report deframer.
// Loads records into the output register: one for an ack frame, and for a data frame
// records built from payload bytes read from the store. Depends on rrd_pkg.
`default_nettype none

module rrd_emit
    import rrd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int GATE_COUNT      = GATE_COUNT_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  cmd_t                                    cmd,
    output logic                                    busy,
    output logic                                    rd_en,
    output logic      [$clog2(MAX_FRAME_BYTES)-1:0] rd_addr,
    input  wire logic [7:0]                         rd_data,
    output logic                                    record_valid,
    input  wire logic                               record_ready,
    output logic      [1:0]                         record_kind,
    output logic      [7:0]                         target_state,
    output logic      [15:0]                        moving_distance,
    output logic      [7:0]                         moving_energy,
    output logic      [15:0]                        still_distance,
    output logic      [7:0]                         still_energy,
    output logic      [15:0]                        detect_distance,
    output logic      [3:0]                         gate_number,
    output logic      [7:0]                         moving_value,
    output logic      [7:0]                         still_value,
    output logic                                    last_of_frame
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    localparam logic [7:0] ADDR_REPORT     = 8'd8;
    localparam logic [7:0] ADDR_HEADER     = 8'd17;
    localparam logic [7:0] ADDR_GATE_MOV   = 8'd19;
    localparam logic [7:0] ADDR_GATE_STILL = 8'd28;
    localparam logic [3:0] REPORT_BYTES    = 4'd9;
    localparam logic [3:0] PAIR_BYTES      = 4'd2;

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_READ = 4'b0010,
        E_WAIT = 4'b0100,
        E_LOAD = 4'b1000
    } state_t;

    function automatic logic [7:0] rec_addr(input logic [REC_W-1:0] rec,
                                            input logic [3:0] idx);
        logic [7:0] g;
        g = 8'(rec) - 8'd2;
        if (rec == '0)
        begin
            rec_addr = ADDR_REPORT + {4'd0, idx};
        end
        else if (rec == REC_W'(1))
        begin
            rec_addr = ADDR_HEADER + {4'd0, idx};
        end
        else if (idx == 4'd0)
        begin
            rec_addr = ADDR_GATE_MOV + g;
        end
        else
        begin
            rec_addr = ADDR_GATE_STILL + g;
        end
    endfunction

    state_t           state_reg, state_next;
    logic [REC_W-1:0] rec_reg, rec_next;
    logic [3:0]       idx_reg, idx_next;
    logic             eng_reg, eng_next;
    logic             ack_reg, ack_next;
    logic             pend_reg;
    logic [71:0]      data_reg;
    logic             valid_reg;

    logic [3:0]       nbytes;
    logic             last_byte;
    logic             last_rec;
    logic             slot_free;
    logic             load;
    logic [7:0]       addr8;
    kind_t            kind;

    assign nbytes    = (rec_reg == '0) ? REPORT_BYTES : PAIR_BYTES;
    assign last_byte = idx_reg == (nbytes - 4'd1);
    assign last_rec  = ack_reg || ((rec_reg == '0) && !eng_reg)
                       || (rec_reg == REC_W'(GATE_COUNT + 1));
    assign slot_free = !valid_reg || record_ready;
    assign load      = (state_reg == E_LOAD) && slot_free;
    assign addr8     = rec_addr(rec_reg, idx_reg);

    assign busy    = state_reg != E_IDLE;
    assign rd_en   = state_reg == E_READ;
    assign rd_addr = AW'(addr8);

    always_comb
    begin
        state_next = state_reg;
        rec_next   = rec_reg;
        idx_next   = idx_reg;
        eng_next   = eng_reg;
        ack_next   = ack_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (cmd.start_ack)
                begin
                    ack_next   = 1'b1;
                    state_next = E_LOAD;
                end
                else if (cmd.start_data)
                begin
                    ack_next   = 1'b0;
                    eng_next   = cmd.eng;
                    rec_next   = '0;
                    idx_next   = 4'd0;
                    state_next = E_READ;
                end
            end
            E_READ:
            begin
                if (last_byte)
                begin
                    state_next = E_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            E_WAIT:
            begin
                state_next = E_LOAD;
            end
            E_LOAD:
            begin
                if (slot_free)
                begin
                    if (last_rec)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        rec_next   = rec_reg + REC_W'(1);
                        idx_next   = 4'd0;
                        state_next = E_READ;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            rec_reg   <= '0;
            idx_reg   <= 4'd0;
            eng_reg   <= 1'b0;
            ack_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rec_reg   <= rec_next;
            idx_reg   <= idx_next;
            eng_reg   <= eng_next;
            ack_reg   <= ack_next;
            pend_reg  <= rd_en;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (record_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Store bytes enter at the top, so the first byte read ends up lowest.
    always_comb
    begin
        if (ack_reg)
        begin
            kind = KIND_ACK;
        end
        else if (rec_reg == '0)
        begin
            kind = KIND_BASIC;
        end
        else if (rec_reg == REC_W'(1))
        begin
            kind = KIND_HEADER;
        end
        else
        begin
            kind = KIND_GATE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            data_reg <= {rd_data, data_reg[71:8]};
        end
        if (load)
        begin
            record_kind     <= kind;
            target_state    <= 8'd0;
            moving_distance <= 16'd0;
            moving_energy   <= 8'd0;
            still_distance  <= 16'd0;
            still_energy    <= 8'd0;
            detect_distance <= 16'd0;
            gate_number     <= 4'd0;
            moving_value    <= 8'd0;
            still_value     <= 8'd0;
            last_of_frame   <= last_rec;
            case (kind)
                KIND_BASIC:
                begin
                    target_state    <= data_reg[7:0];
                    moving_distance <= data_reg[23:8];
                    moving_energy   <= data_reg[31:24];
                    still_distance  <= data_reg[47:32];
                    still_energy    <= data_reg[55:48];
                    detect_distance <= data_reg[71:56];
                end
                KIND_HEADER:
                begin
                    moving_value <= data_reg[63:56];
                    still_value  <= data_reg[71:64];
                end
                KIND_GATE:
                begin
                    gate_number  <= 4'(rec_reg - REC_W'(2));
                    moving_value <= data_reg[63:56];
                    still_value  <= data_reg[71:64];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign record_valid = valid_reg;

    // A new frame end must never arrive while records of the previous frame are pending.
    a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_ack || cmd.start_data) |-> (state_reg == E_IDLE))
        else $error("Frame end arrived while the emitter was busy.");

    // Reads of one record stay within its byte count.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_READ) |-> (idx_reg < nbytes))
        else $error("Read index beyond record length.");

    // A record is only loaded once all its store reads have landed.
    a_load_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_LOAD) |-> !pend_reg && !rd_en)
        else $error("Record loaded with a store read outstanding.");

endmodule

`default_nettype wire
